### hw/rtl/lzfd_pkg.sv
package lzfd_pkg;

  // Field widths of the payload
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CountW  = 32;
  localparam int unsigned DistW   = 12;
  localparam int unsigned LenW    = 5;
  localparam int unsigned ErrW    = 2;
  localparam int unsigned BitsW   = 4;
  localparam int unsigned OutDataW = 48;  // 43 field bits padded to whole bytes

  localparam logic [LenW-1:0]   MinMatch     = LenW'(3);
  localparam logic [BitsW-1:0]  FlagsPerCtrl = BitsW'(7);  // left after the first flag
  localparam logic [CountW-1:0] HeaderBytes  = CountW'(8);
  localparam logic [CountW-1:0] RawSizeReset = CountW'(1);

  localparam logic [ErrW-1:0] ErrNone     = 2'd0;
  localparam logic [ErrW-1:0] ErrBadDist  = 2'd1;
  localparam logic [ErrW-1:0] ErrShort    = 2'd2;

  typedef enum logic [1:0] {
    PH_TOKEN,
    PH_LITERAL,
    PH_MATCH1,
    PH_MATCH2
  } phase_e;

  typedef enum logic [1:0] {
    HALT_RUN,
    HALT_DONE,
    HALT_BAD_DIST,
    HALT_SHORT
  } halt_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_READ,
    ST_WRITE
  } ctrl_state_e;

  typedef struct packed {
    logic accept;  // latch the incoming packed byte
    logic decode;  // commit the parse step for the latched byte
    logic push;    // load the single result of a non-copy step
    logic read;    // issue a history read for the next copied byte
    logic write;   // emit and store the copied byte
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;   // output register can take a result this cycle
    logic copy;       // latched byte starts a valid match copy
    logic copy_last;  // current copied byte is the last of the match
  } dp_status_t;

endpackage

### hw/rtl/lzfd_ctrl.sv
module lzfd_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  lzfd_pkg::dp_status_t    status_i,
  output lzfd_pkg::ctrl_cmd_t     cmd_o
);

  lzfd_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lzfd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      lzfd_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = lzfd_pkg::ST_DECODE;
        end
      end
      lzfd_pkg::ST_DECODE: begin
        if (status_i.copy) begin
          cmd_o.decode = 1'b1;
          state_d      = lzfd_pkg::ST_READ;
        end else if (status_i.out_free) begin
          cmd_o.decode = 1'b1;
          cmd_o.push   = 1'b1;
          state_d      = lzfd_pkg::ST_IDLE;
        end
      end
      lzfd_pkg::ST_READ: begin
        cmd_o.read = 1'b1;
        state_d    = lzfd_pkg::ST_WRITE;
      end
      lzfd_pkg::ST_WRITE: begin
        if (status_i.out_free) begin
          cmd_o.write = 1'b1;
          state_d     = status_i.copy_last ? lzfd_pkg::ST_IDLE : lzfd_pkg::ST_READ;
        end
      end
    endcase
  end

endmodule

### hw/rtl/lzfd_datapath.sv
module lzfd_datapath #(
  parameter int unsigned WINDOW_SIZE = 4096
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lzfd_pkg::ctrl_cmd_t                 cmd_i,
  output lzfd_pkg::dp_status_t                status_o,
  input  logic [lzfd_pkg::CountW-1:0]         raw_size_i,
  input  logic [lzfd_pkg::ByteW-1:0]          in_byte_i,
  input  logic                                in_last_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [lzfd_pkg::ByteW-1:0]          out_byte_o,
  output logic                                out_flag_o,
  output logic                                out_last_o,
  output logic                                out_fin_o,
  output logic [lzfd_pkg::ErrW-1:0]           out_err_o,
  output logic [lzfd_pkg::CountW-1:0]         out_used_o
);

  localparam int unsigned AddrW = $clog2(WINDOW_SIZE);
  localparam logic [AddrW:0] WinSize  = (AddrW+1)'(WINDOW_SIZE);
  localparam logic [AddrW-1:0] WinLast = AddrW'(WINDOW_SIZE - 1);

  // Latched input and parse state
  logic [lzfd_pkg::ByteW-1:0]  in_byte_q;
  logic                        in_last_q;
  logic [lzfd_pkg::ByteW-1:0]  control_q, control_d;
  logic [lzfd_pkg::BitsW-1:0]  bits_left_q, bits_left_d;
  lzfd_pkg::phase_e            phase_q, phase_d;
  lzfd_pkg::halt_e             halt_q, halt_d;
  logic [lzfd_pkg::ByteW-1:0]  match_first_q, match_first_d;
  logic [lzfd_pkg::CountW-1:0] produced_q, produced_d;
  logic [lzfd_pkg::CountW-1:0] consumed_q, consumed_d;
  logic [AddrW-1:0]            wr_ptr_q, wr_ptr_d;
  logic [lzfd_pkg::LenW-1:0]   copy_left_q, copy_left_d;

  // History
  logic [lzfd_pkg::ByteW-1:0]  hist_mem [WINDOW_SIZE];
  logic [lzfd_pkg::ByteW-1:0]  rd_data_q;
  logic [AddrW-1:0]            rd_addr;
  logic [AddrW:0]              rd_diff;
  logic                        mem_we;
  logic [lzfd_pkg::ByteW-1:0]  mem_wdata;

  // Output register
  logic                        out_valid_q;
  logic [lzfd_pkg::ByteW-1:0]  out_byte_q;
  logic                        out_flag_q, out_last_q, out_fin_q;
  logic [lzfd_pkg::ErrW-1:0]   out_err_q;
  logic [lzfd_pkg::CountW-1:0] out_used_q;

  // Decode terms
  logic                        start_done, running;
  logic [lzfd_pkg::CountW-1:0] remaining;
  logic [lzfd_pkg::DistW-1:0]  match_dist;
  logic [lzfd_pkg::LenW-1:0]   len;
  logic                        bad_dist, lit_done, copy_done;
  logic [lzfd_pkg::LenW-1:0]   copy_n;
  logic                        is_literal;
  logic                        tok_end, tok_fin;
  logic                        push;
  logic                        out_free;

  assign start_done = (halt_q == lzfd_pkg::HALT_RUN) && (produced_q >= raw_size_i);
  assign running    = (halt_q == lzfd_pkg::HALT_RUN) && !start_done;
  assign remaining  = raw_size_i - produced_q;
  assign match_dist = {match_first_q[7:4], in_byte_q};
  assign len        = lzfd_pkg::LenW'(match_first_q[3:0]) + lzfd_pkg::MinMatch;
  assign bad_dist   = (match_dist == '0) ||
                      (lzfd_pkg::CountW'(match_dist) > produced_q);
  assign lit_done   = (remaining == lzfd_pkg::CountW'(1));
  assign copy_done  = (remaining <= lzfd_pkg::CountW'(len));
  assign copy_n     = copy_done ? remaining[lzfd_pkg::LenW-1:0] : len;
  assign is_literal = running && (phase_q == lzfd_pkg::PH_LITERAL);

  assign out_free = !out_valid_q || out_ready_i;

  assign status_o.out_free  = out_free;
  assign status_o.copy      = running && (phase_q == lzfd_pkg::PH_MATCH2) && !bad_dist;
  assign status_o.copy_last = (copy_left_q == lzfd_pkg::LenW'(1));

  always_comb begin
    control_d     = control_q;
    bits_left_d   = bits_left_q;
    phase_d       = phase_q;
    halt_d        = halt_q;
    match_first_d = match_first_q;
    consumed_d    = consumed_q;
    copy_left_d   = copy_left_q;
    tok_end       = 1'b0;
    tok_fin       = 1'b0;
    if (cmd_i.decode) begin
      if (start_done) begin
        halt_d = lzfd_pkg::HALT_DONE;
      end
      if (running) begin
        if (consumed_q != '1) begin
          consumed_d = consumed_q + lzfd_pkg::CountW'(1);
        end
        unique case (phase_q)
          lzfd_pkg::PH_TOKEN: begin
            control_d   = {in_byte_q[6:0], 1'b0};
            bits_left_d = lzfd_pkg::FlagsPerCtrl;
            phase_d     = in_byte_q[7] ? lzfd_pkg::PH_MATCH1 : lzfd_pkg::PH_LITERAL;
          end
          lzfd_pkg::PH_LITERAL: begin
            tok_end = 1'b1;
            tok_fin = lit_done;
          end
          lzfd_pkg::PH_MATCH1: begin
            match_first_d = in_byte_q;
            phase_d       = lzfd_pkg::PH_MATCH2;
          end
          lzfd_pkg::PH_MATCH2: begin
            if (bad_dist) begin
              halt_d = lzfd_pkg::HALT_BAD_DIST;
            end else begin
              tok_end     = 1'b1;
              tok_fin     = copy_done;
              copy_left_d = copy_n;
            end
          end
        endcase
        // Token finished: stop, take the next flag, or wait for a control byte
        if (tok_end) begin
          priority if (tok_fin) begin
            halt_d = lzfd_pkg::HALT_DONE;
          end else if (bits_left_q != '0) begin
            control_d   = {control_q[6:0], 1'b0};
            bits_left_d = bits_left_q - lzfd_pkg::BitsW'(1);
            phase_d     = control_q[7] ? lzfd_pkg::PH_MATCH1 : lzfd_pkg::PH_LITERAL;
          end else begin
            phase_d = lzfd_pkg::PH_TOKEN;
          end
        end
        if ((halt_d == lzfd_pkg::HALT_RUN) && in_last_q) begin
          halt_d = lzfd_pkg::HALT_SHORT;
        end
      end
    end else if (cmd_i.write) begin
      copy_left_d = copy_left_q - lzfd_pkg::LenW'(1);
    end
  end

  // History write pointer tracks produced_count modulo the window
  assign mem_we    = (cmd_i.decode && is_literal) || cmd_i.write;
  assign mem_wdata = cmd_i.write ? rd_data_q : in_byte_q;
  assign produced_d = mem_we ? produced_q + lzfd_pkg::CountW'(1) : produced_q;
  assign wr_ptr_d   = !mem_we ? wr_ptr_q :
                      (wr_ptr_q == WinLast) ? '0 : wr_ptr_q + AddrW'(1);

  assign rd_diff = {1'b0, wr_ptr_q} - (AddrW+1)'(match_dist);
  assign rd_addr = rd_diff[AddrW] ? AddrW'(rd_diff + WinSize) : rd_diff[AddrW-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hist_mem[wr_ptr_q] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      rd_data_q <= hist_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      in_byte_q <= in_byte_i;
      in_last_q <= in_last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      control_q     <= '0;
      bits_left_q   <= '0;
      phase_q       <= lzfd_pkg::PH_TOKEN;
      halt_q        <= lzfd_pkg::HALT_RUN;
      match_first_q <= '0;
      produced_q    <= '0;
      consumed_q    <= lzfd_pkg::HeaderBytes;
      wr_ptr_q      <= '0;
      copy_left_q   <= '0;
    end else begin
      control_q     <= control_d;
      bits_left_q   <= bits_left_d;
      phase_q       <= phase_d;
      halt_q        <= halt_d;
      match_first_q <= match_first_d;
      produced_q    <= produced_d;
      consumed_q    <= consumed_d;
      wr_ptr_q      <= wr_ptr_d;
      copy_left_q   <= copy_left_d;
    end
  end

  // Output register: status fields always show the state after the step
  assign push = (cmd_i.decode && cmd_i.push) || cmd_i.write;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_flag_q <= cmd_i.write || is_literal;
      out_byte_q <= cmd_i.write ? rd_data_q :
                    is_literal ? in_byte_q : '0;
      out_last_q <= cmd_i.write ? status_o.copy_last : 1'b1;
      out_fin_q  <= (halt_d == lzfd_pkg::HALT_DONE);
      out_used_q <= (halt_d == lzfd_pkg::HALT_DONE) ? consumed_d : '0;
      unique case (halt_d)
        lzfd_pkg::HALT_BAD_DIST: out_err_q <= lzfd_pkg::ErrBadDist;
        lzfd_pkg::HALT_SHORT:    out_err_q <= lzfd_pkg::ErrShort;
        lzfd_pkg::HALT_RUN,
        lzfd_pkg::HALT_DONE:     out_err_q <= lzfd_pkg::ErrNone;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_flag_o  = out_flag_q;
  assign out_last_o  = out_last_q;
  assign out_fin_o   = out_fin_q;
  assign out_err_o   = out_err_q;
  assign out_used_o  = out_used_q;

endmodule

### hw/rtl/lzss_flagbit_decompressor.sv
// Flow: a control byte, a literal or the first match byte is captured into the input latch,
//   then decoded into the output register once that register is free.
// A new packed byte is taken only after the last one is through; a match then loops a history
//   read, then an emit, per copied byte, for 3 to 18 bytes (fewer if raw_size ends first).
// The single-port-read history memory with registered read data sets the copy rate.
// Reset (rst_ni low, asynchronous): parser and produced count clear, packed_used returns to 8
//   and raw_size to 1; history stays undefined and is never read before it is written.
module lzss_flagbit_decompressor #(
  parameter int unsigned WINDOW_SIZE = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Packed input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [lzfd_pkg::ByteW-1:0]        s_axis_tdata,   // [7:0] packed_byte
  input  logic                              s_axis_tlast,   // end_of_input
  // Decoded output stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [lzfd_pkg::OutDataW-1:0]     m_axis_tdata,   // [7:0] out_byte, [8] finished,
                                                            // [10:9] error_code,
                                                            // [42:11] packed_used, [47:43] zero
  output logic                              m_axis_tuser,   // out_flag: out_byte holds a decoded byte
  output logic                              m_axis_tlast,   // last_of_run
  // raw_size configuration write
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [lzfd_pkg::CountW-1:0]       cfg_data_i
);

  localparam int unsigned PadW = lzfd_pkg::OutDataW - lzfd_pkg::ByteW - 1 -
                                 lzfd_pkg::ErrW - lzfd_pkg::CountW;

  logic [lzfd_pkg::CountW-1:0] raw_size_q;
  lzfd_pkg::ctrl_cmd_t         cmd;
  lzfd_pkg::dp_status_t        status;
  logic [lzfd_pkg::ByteW-1:0]  out_byte;
  logic                        out_fin;
  logic [lzfd_pkg::ErrW-1:0]   out_err;
  logic [lzfd_pkg::CountW-1:0] out_used;

  // raw_size register; write it only while no item is in flight (the block does not enforce this)
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_size_q <= lzfd_pkg::RawSizeReset;
    end else if (cfg_valid_i) begin
      raw_size_q <= cfg_data_i;
    end
  end

  // Sequencer: capture a byte, decode it, then loop read/emit for match copies
  lzfd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Parse state, history memory and output register
  lzfd_datapath #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .raw_size_i  (raw_size_q),
    .in_byte_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (out_byte),
    .out_flag_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast),
    .out_fin_o   (out_fin),
    .out_err_o   (out_err),
    .out_used_o  (out_used)
  );

  // Pack result fields, lowest field first
  assign m_axis_tdata = {{PadW{1'b0}}, out_used, out_err, out_fin, out_byte};

endmodule

### hw/rtl/lzfd_checker.sv
module lzfd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [lzfd_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                          m_axis_tuser,
  input logic                          m_axis_tlast
);

  // Hold the result while the sink stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");

  // A status-only result carries a zero byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[7:0] == 8'd0)
    else $error("status result with nonzero byte");

  // A status-only result is always the only result of its transfer run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
    else $error("status result not last");

  // Finished never carries an error
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[8] |-> m_axis_tdata[10:9] == lzfd_pkg::ErrNone)
    else $error("finished with error");

  // Packed byte count shows only once finished
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[8] |-> m_axis_tdata[42:11] == 32'd0)
    else $error("packed_used set before finish");

endmodule

bind lzss_flagbit_decompressor lzfd_checker u_lzfd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
